### rtl/rcfd_pkg.sv
// Shared types and constants for the RC frame channel decoder.
package rcfd_pkg;

    // Framing constants
    localparam logic [7:0] SBUS_HEAD     = 8'h0F;
    localparam logic [7:0] CRSF_SYNC     = 8'hEA;
    localparam logic [7:0] CRSF_TYPE_RC  = 8'h16;
    localparam int         SBUS_LAST_POS = 24;
    localparam int         SBUS_BASE     = 1;
    localparam int         CRSF_BASE     = 3;

    // Channel layout
    localparam int NUM_CHANNELS = 16;
    localparam int CH_BITS      = 11;
    localparam int FRAME_BITS   = NUM_CHANNELS * CH_BITS;
    localparam int FRAME_SPAN   = FRAME_BITS / 8;
    // Highest byte index that channel capture ever reads, plus two
    localparam int STORE_BYTES  = CRSF_BASE + FRAME_SPAN + 1;

    // Queue between parser and unpacker
    localparam int QUEUE_DEPTH  = 2;
    localparam int QPTR_W       = $clog2(QUEUE_DEPTH);

    typedef logic [FRAME_BITS-1:0]          frame_t;
    typedef logic [$clog2(NUM_CHANNELS)-1:0] ch_idx_t;
    typedef logic [CH_BITS-1:0]              ch_val_t;

    // Queue status seen by both sides
    typedef struct packed {
        logic full;
        logic nonempty;
    } q_stat_t;

endpackage

### rtl/rcfd_front.sv
// Byte parser: frames SBUS or CRSF, keeps the byte store, captures channel bits.
module rcfd_front #(
    parameter int FRAME_BYTES = 32
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_valid,
    input  logic                   mode_in,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [7:0]             rx_byte,
    input  rcfd_pkg::q_stat_t      q_stat,
    output logic                   push,
    output rcfd_pkg::frame_t       push_frame
);

    localparam int PW = $clog2(FRAME_BYTES + 1);

    // CRSF parse phases
    localparam logic [1:0] PH_HUNT    = 2'd0;
    localparam logic [1:0] PH_LENGTH  = 2'd1;
    localparam logic [1:0] PH_TYPE    = 2'd2;
    localparam logic [1:0] PH_PAYLOAD = 2'd3;

    logic          mode_reg;
    logic [1:0]    phase_reg, phase_next;
    logic [PW-1:0] pos_reg, pos_next;
    logic [7:0]    len_reg, len_next;
    logic [7:0]    store_reg  [rcfd_pkg::STORE_BYTES];
    logic [7:0]    store_next [rcfd_pkg::STORE_BYTES];
    logic          wr_en;
    logic          sync_wr;
    logic          done;
    logic          accept;

    assign in_ready = !q_stat.full;
    assign accept   = in_valid && in_ready;

    // Parse one byte
    always_comb
    begin
        phase_next = phase_reg;
        pos_next   = pos_reg;
        len_next   = len_reg;
        wr_en      = 1'b0;
        sync_wr    = 1'b0;
        done       = 1'b0;
        if (!mode_reg)
        begin
            if (pos_reg != '0)
            begin
                wr_en = 1'b1;
                if (pos_reg < PW'(rcfd_pkg::SBUS_LAST_POS))
                begin
                    pos_next = pos_reg + PW'(1);
                end
                else
                begin
                    pos_next = '0;
                    done     = 1'b1;
                end
            end
            if (pos_next == '0 && rx_byte == rcfd_pkg::SBUS_HEAD)
            begin
                sync_wr  = 1'b1;
                pos_next = PW'(1);
            end
        end
        else
        begin
            unique case (phase_reg)
                PH_PAYLOAD:
                begin
                    if (pos_reg >= PW'(FRAME_BYTES))
                    begin
                        phase_next = PH_HUNT;
                    end
                    else
                    begin
                        wr_en    = 1'b1;
                        pos_next = pos_reg + PW'(1);
                        if (9'(pos_next) == {1'b0, len_reg} + 9'd2)
                        begin
                            phase_next = PH_HUNT;
                            done       = 1'b1;
                        end
                    end
                end
                PH_TYPE:
                begin
                    wr_en      = 1'b1;
                    pos_next   = pos_reg + PW'(1);
                    phase_next = (rx_byte == rcfd_pkg::CRSF_TYPE_RC) ? PH_PAYLOAD : PH_HUNT;
                end
                PH_LENGTH:
                begin
                    wr_en      = 1'b1;
                    pos_next   = pos_reg + PW'(1);
                    len_next   = rx_byte;
                    phase_next = PH_TYPE;
                end
                default:
                begin
                    phase_next = PH_HUNT;
                end
            endcase
            if (rx_byte == rcfd_pkg::CRSF_SYNC)
            begin
                sync_wr    = 1'b1;
                pos_next   = PW'(1);
                phase_next = PH_LENGTH;
            end
        end
    end

    // Merge this byte's writes into the store
    always_comb
    begin
        for (int i = 0; i < rcfd_pkg::STORE_BYTES; i++)
        begin
            store_next[i] = store_reg[i];
            if (wr_en && pos_reg == PW'(i))
            begin
                store_next[i] = rx_byte;
            end
        end
        if (sync_wr)
        begin
            store_next[0] = rx_byte;
        end
    end

    // Capture the channel bytes from the updated store
    always_comb
    begin
        for (int j = 0; j < rcfd_pkg::FRAME_SPAN; j++)
        begin
            push_frame[8*j +: 8] = mode_reg ? store_next[j + rcfd_pkg::CRSF_BASE]
                                            : store_next[j + rcfd_pkg::SBUS_BASE];
        end
    end

    assign push = accept && done;

    // Hold parse state; a mode write restarts framing
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= 1'b0;
            phase_reg <= PH_HUNT;
            pos_reg   <= '0;
            len_reg   <= '0;
            for (int i = 0; i < rcfd_pkg::STORE_BYTES; i++)
            begin
                store_reg[i] <= '0;
            end
        end
        else if (cfg_valid)
        begin
            mode_reg  <= mode_in;
            phase_reg <= PH_HUNT;
            pos_reg   <= '0;
            len_reg   <= '0;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            pos_reg   <= pos_next;
            len_reg   <= len_next;
            for (int i = 0; i < rcfd_pkg::STORE_BYTES; i++)
            begin
                store_reg[i] <= store_next[i];
            end
        end
    end

endmodule

### rtl/rcfd_queue.sv
// Short frame queue between the parser and the channel unpacker.
module rcfd_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  rcfd_pkg::frame_t  push_frame,
    input  logic              pop,
    output rcfd_pkg::frame_t  pop_frame,
    output rcfd_pkg::q_stat_t q_stat
);

    localparam int CW = $clog2(rcfd_pkg::QUEUE_DEPTH + 1);

    rcfd_pkg::frame_t           q_mem [rcfd_pkg::QUEUE_DEPTH];
    logic [rcfd_pkg::QPTR_W-1:0] wptr_reg, wptr_next;
    logic [rcfd_pkg::QPTR_W-1:0] rptr_reg, rptr_next;
    logic [CW-1:0]               count_reg, count_next;
    logic                        do_push;
    logic                        do_pop;

    assign q_stat.full     = (count_reg == CW'(rcfd_pkg::QUEUE_DEPTH));
    assign q_stat.nonempty = (count_reg != '0);
    assign do_push         = push && !q_stat.full;
    assign do_pop          = pop && q_stat.nonempty;
    assign pop_frame       = q_mem[rptr_reg];

    // Advance pointers and occupancy
    always_comb
    begin
        wptr_next  = wptr_reg;
        rptr_next  = rptr_reg;
        count_next = count_reg;
        if (do_push)
        begin
            wptr_next = (wptr_reg == rcfd_pkg::QPTR_W'(rcfd_pkg::QUEUE_DEPTH - 1))
                        ? '0 : wptr_reg + rcfd_pkg::QPTR_W'(1);
        end
        if (do_pop)
        begin
            rptr_next = (rptr_reg == rcfd_pkg::QPTR_W'(rcfd_pkg::QUEUE_DEPTH - 1))
                        ? '0 : rptr_reg + rcfd_pkg::QPTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    // Store frame data
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            q_mem[wptr_reg] <= push_frame;
        end
    end

endmodule

### rtl/rcfd_back.sv
// Channel unpacker: shifts out sixteen 11-bit channels through an output register.
module rcfd_back (
    input  logic               clk,
    input  logic               rst_n,
    input  rcfd_pkg::q_stat_t  q_stat,
    input  rcfd_pkg::frame_t   pop_frame,
    output logic               pop,
    output logic               out_valid,
    input  logic               out_ready,
    output rcfd_pkg::ch_idx_t  channel_index,
    output rcfd_pkg::ch_val_t  channel_value,
    output logic               last_channel
);

    localparam rcfd_pkg::ch_idx_t LAST_IDX = rcfd_pkg::ch_idx_t'(rcfd_pkg::NUM_CHANNELS - 1);

    logic               busy_reg, busy_next;
    rcfd_pkg::ch_idx_t  k_reg, k_next;
    rcfd_pkg::frame_t   sh_reg, sh_next;
    logic               out_valid_reg, out_valid_next;
    rcfd_pkg::ch_idx_t  idx_reg, idx_next;
    rcfd_pkg::ch_val_t  val_reg, val_next;
    logic               last_reg, last_next;
    logic               emit;

    assign emit = busy_reg && (!out_valid_reg || out_ready);
    assign pop  = !busy_reg && q_stat.nonempty;

    // Load a frame, then emit one channel per free output slot
    always_comb
    begin
        busy_next      = busy_reg;
        k_next         = k_reg;
        sh_next        = sh_reg;
        out_valid_next = out_valid_reg && !out_ready;
        idx_next       = idx_reg;
        val_next       = val_reg;
        last_next      = last_reg;
        if (pop)
        begin
            busy_next = 1'b1;
            k_next    = '0;
            sh_next   = pop_frame;
        end
        else if (emit)
        begin
            out_valid_next = 1'b1;
            idx_next       = k_reg;
            val_next       = sh_reg[rcfd_pkg::CH_BITS-1:0];
            last_next      = (k_reg == LAST_IDX);
            sh_next        = sh_reg >> rcfd_pkg::CH_BITS;
            k_next         = k_reg + rcfd_pkg::ch_idx_t'(1);
            if (k_reg == LAST_IDX)
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            k_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            k_reg         <= k_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        sh_reg   <= sh_next;
        idx_reg  <= idx_next;
        val_reg  <= val_next;
        last_reg <= last_next;
    end

    assign out_valid     = out_valid_reg;
    assign channel_index = idx_reg;
    assign channel_value = val_reg;
    assign last_channel  = last_reg;

endmodule

### rtl/rc_frame_channel_decoder_core.sv
// Top level of the RC frame channel decoder: parser, frame queue and unpacker.
//
//   Port group   Direction  Handshake              Payload
//   cfg          in         cfg_valid/cfg_ready    protocol_mode
//   in           in         in_valid/in_ready      rx_byte
//   out          out        out_valid/out_ready    channel_index, channel_value, last_channel
//
// The parser takes one byte per cycle while in_ready is high; a byte that completes a
// frame pushes its channel bits into a two-entry queue. The unpacker loads a frame, then
// makes 16 channel transactions, one per cycle unless stalled, before the next load.
// in_ready drops only while the queue is full; out_ready low stalls only the unpacker.
// Reset clears the byte store, parse state and mode (SBUS); no clearing pass.
module rc_frame_channel_decoder_core #(
    parameter int FRAME_BYTES = 32
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic                  protocol_mode,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [7:0]            rx_byte,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [3:0]            channel_index,
    output logic [10:0]           channel_value,
    output logic                  last_channel
);

    rcfd_pkg::q_stat_t q_stat;
    logic              push;
    logic              pop;
    rcfd_pkg::frame_t  push_frame;
    rcfd_pkg::frame_t  pop_frame;

    assign cfg_ready = 1'b1;

    rcfd_front #(
        .FRAME_BYTES (FRAME_BYTES)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .mode_in    (protocol_mode),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .rx_byte    (rx_byte),
        .q_stat     (q_stat),
        .push       (push),
        .push_frame (push_frame)
    );

    rcfd_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_frame (push_frame),
        .pop        (pop),
        .pop_frame  (pop_frame),
        .q_stat     (q_stat)
    );

    rcfd_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_stat        (q_stat),
        .pop_frame     (pop_frame),
        .pop           (pop),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .channel_index (channel_index),
        .channel_value (channel_value),
        .last_channel  (last_channel)
    );

endmodule

### rtl/rcfd_checker.sv
// Port-level checks on the decoder output stream, bound to the top level.
module rcfd_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic [3:0]  channel_index,
    input logic [10:0] channel_value,
    input logic        last_channel
);

    // Stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(channel_index)
        && $stable(channel_value) && $stable(last_channel))
        else $error("stalled channel transaction changed");

    // Last marker on the final channel and on no other
    a_last_idx: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (last_channel != (channel_index == 4'd15)) |-> 1'b0)
        else $error("last_channel does not match channel 15");

    // A frame's channels follow with no gap
    a_no_gap: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !last_channel |=> out_valid)
        else $error("gap inside a frame's channel burst");

    // Channels come in order
    a_order: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !last_channel |=>
        channel_index == $past(channel_index) + 4'd1)
        else $error("channel index out of order");

endmodule

bind rc_frame_channel_decoder_core rcfd_checker u_rcfd_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .channel_index (channel_index),
    .channel_value (channel_value),
    .last_channel  (last_channel)
);
